/* src/tdip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdip_pkg
// Shared widths, constants and types for the torque to dipole pipeline.
// ----------------------------------------------------------------------------
package tdip_pkg;
    localparam int FIELD_W  = 18;
    localparam int TORQUE_W = 25;
    localparam int DIPOLE_W = 24;
    localparam int THR_W    = 36;
    localparam int DEN_W    = 36;
    localparam int NUM_W    = 52;
    localparam int MAG_W    = 43;
    localparam int CROSS_W  = 44;
    localparam int SQ_W     = 36;
    localparam int PROD_W   = FIELD_W + TORQUE_W;
    localparam int SIN_W    = 136;
    localparam int MOUT_W   = 72;
    localparam int MUSER_W  = 2;
    localparam int LANE_LAT = DIPOLE_W + 2;
    localparam int PIPE_LEN = 4 + LANE_LAT;
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1);
    localparam logic [9:0]         UNIT_SCALE = 10'd1000;
    localparam logic [DIPOLE_W-1:0] DIP_POS_MAX = {1'b0, {(DIPOLE_W-1){1'b1}}};
    localparam logic [DIPOLE_W-1:0] DIP_NEG_MIN = {1'b1, {(DIPOLE_W-1){1'b0}}};

    typedef struct packed {
        logic neg;
        logic too_weak;
    } t_lane_ctl;
endpackage

/* src/tdip_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdip_div
// One dipole lane: pipelined restoring divide, one quotient bit per stage,
// with saturation to the signed dipole range and a zero result on weak field.
// ----------------------------------------------------------------------------
module tdip_div
    import tdip_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    input  t_lane_ctl                  i_ctl,
    output logic signed [DIPOLE_W-1:0] o_dipole,
    output logic                       o_sat
);
    localparam int QW = DIPOLE_W;
    localparam int CW = DEN_W + QW;

    logic [NUM_W-1:0] r_rem [0:QW];
    logic [QW-1:0]    r_q   [0:QW];
    logic [DEN_W-1:0] r_den [0:QW];
    t_lane_ctl        r_ctl [0:QW];
    logic             r_ovf [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ctl[0] <= i_ctl;
            r_ovf[0] <= {{(CW-NUM_W){1'b0}}, i_num} >= {i_den, {QW{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [CW-1:0]    n_sh;
        logic             n_take;
        logic [QW-1:0]    n_q;
        logic [NUM_W-1:0] n_rem;
        always_comb begin
            n_sh   = {{QW{1'b0}}, r_den[k-1]} << B;
            n_take = {{(CW-NUM_W){1'b0}}, r_rem[k-1]} >= n_sh;
            n_q    = r_q[k-1];
            n_rem  = r_rem[k-1];
            if (n_take) begin
                n_q[B] = 1'b1;
                n_rem  = r_rem[k-1] - n_sh[NUM_W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_den[k] <= r_den[k-1];
                r_ctl[k] <= r_ctl[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    logic                n_sat;
    logic [DIPOLE_W-1:0] n_dip;

    always_comb begin
        n_sat = 1'b0;
        n_dip = '0;
        if (!r_ctl[QW].too_weak) begin
            if (r_ctl[QW].neg) begin
                n_sat = r_ovf[QW] || (r_q[QW][QW-1] && (|r_q[QW][QW-2:0]));
                n_dip = n_sat ? DIP_NEG_MIN : (~r_q[QW] + 1'b1);
            end else begin
                n_sat = r_ovf[QW] || r_q[QW][QW-1];
                n_dip = n_sat ? DIP_POS_MAX : r_q[QW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_dipole <= n_dip;
            o_sat    <= n_sat;
        end
    end
endmodule

/* src/torque_to_magnetic_dipole.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torque_to_magnetic_dipole
// Torque-rod dipole request: (B x tau) * 1000 / |B|^2, saturated to 24 bits.
// ----------------------------------------------------------------------------
// Usage:
//  Slave stream carries one beat per sample: field x/y/z (18b signed, nT) and
//  torque x/y/z (25b signed, nN*m). Master stream returns one beat per input:
//  dipole x/y/z (24b signed, mA*m^2) in tdata, flags in tuser.
//  i_cfg_we/i_cfg_wdata load the 36-bit |B|^2 threshold; write only when idle.
//  Throughput: one beat per cycle while the output is not stalled; the
//  24-stage divider pipeline, one quotient bit per stage, sets the depth.
//  Reset clears all valid bits and sets the threshold to 1.
//  A stalled output beat freezes the whole pipeline; o_s_tready stays high
//  while the last stage is empty or being taken, so bubbles still fill.
// ----------------------------------------------------------------------------
module torque_to_magnetic_dipole
    import tdip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_W-1:0]    i_cfg_wdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // field_x, field_y, field_z, torque_x, torque_y, torque_z, zero pad
    input  logic [SIN_W-1:0]    i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // dipole_x, dipole_y, dipole_z
    output logic [MOUT_W-1:0]   o_m_tdata,
    // field_too_weak, clipped
    output logic [MUSER_W-1:0]  o_m_tuser
);
    localparam int LAST = PIPE_LEN - 1;

    logic              r_vld [0:LAST];
    logic [THR_W-1:0]  r_thr;
    logic              ce;

    assign ce         = !r_vld[LAST] || i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) r_vld[i] <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i <= LAST; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    logic signed [FIELD_W-1:0]  bx, by, bz;
    logic signed [TORQUE_W-1:0] tx, ty, tz;
    assign bx = i_s_tdata[17:0];
    assign by = i_s_tdata[35:18];
    assign bz = i_s_tdata[53:36];
    assign tx = i_s_tdata[78:54];
    assign ty = i_s_tdata[103:79];
    assign tz = i_s_tdata[128:104];

    // stage 1: products
    logic signed [SQ_W-1:0]   r1_sq [0:2];
    logic signed [PROD_W-1:0] r1_p  [0:5];
    // stage 2: sums
    logic [DEN_W-1:0]          r2_nsq;
    logic signed [CROSS_W-1:0] r2_c [0:2];
    // stage 3: magnitude, sign, threshold
    logic [DEN_W-1:0]  r3_nsq;
    logic [MAG_W-1:0]  r3_mag [0:2];
    t_lane_ctl         r3_ctl [0:2];
    // stage 4: scale
    logic [DEN_W-1:0]  r4_nsq;
    logic [NUM_W-1:0]  r4_num [0:2];
    t_lane_ctl         r4_ctl [0:2];

    logic r3_weak;
    assign r3_weak = r2_nsq <= r_thr;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_sq[0] <= bx * bx;
            r1_sq[1] <= by * by;
            r1_sq[2] <= bz * bz;
            r1_p[0]  <= by * tz;
            r1_p[1]  <= bz * ty;
            r1_p[2]  <= bz * tx;
            r1_p[3]  <= bx * tz;
            r1_p[4]  <= bx * ty;
            r1_p[5]  <= by * tx;

            r2_nsq  <= DEN_W'(r1_sq[0]) + DEN_W'(r1_sq[1]) + DEN_W'(r1_sq[2]);
            r2_c[0] <= CROSS_W'(r1_p[0]) - CROSS_W'(r1_p[1]);
            r2_c[1] <= CROSS_W'(r1_p[2]) - CROSS_W'(r1_p[3]);
            r2_c[2] <= CROSS_W'(r1_p[4]) - CROSS_W'(r1_p[5]);

            r3_nsq <= r2_nsq;
            for (int i = 0; i < 3; i++) begin
                r3_mag[i]          <= r2_c[i][CROSS_W-1] ? MAG_W'(-r2_c[i]) : MAG_W'(r2_c[i]);
                r3_ctl[i].neg      <= r2_c[i][CROSS_W-1];
                r3_ctl[i].too_weak <= r3_weak;
            end

            r4_nsq <= r3_nsq;
            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= NUM_W'({9'b0, r3_mag[i]} * {42'b0, UNIT_SCALE});
                r4_ctl[i] <= r3_ctl[i];
            end
        end
    end

    logic signed [DIPOLE_W-1:0] dip [0:2];
    logic                       sat [0:2];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tdip_div u_div (
            .i_clk    (i_clk),
            .i_ce     (ce),
            .i_num    (r4_num[g]),
            .i_den    (r4_nsq),
            .i_ctl    (r4_ctl[g]),
            .o_dipole (dip[g]),
            .o_sat    (sat[g])
        );
    end

    logic [LANE_LAT-1:0] r_weak_d;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_weak_d <= {r_weak_d[LANE_LAT-2:0], r4_ctl[0].too_weak};
        end
    end

    assign o_m_tdata = {dip[2], dip[1], dip[0]};
    assign o_m_tuser = {sat[0] | sat[1] | sat[2], r_weak_d[LANE_LAT-1]};

    a_weak_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0 && !o_m_tuser[1])
        else $error("weak field beat carries nonzero dipole");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow pipeline advance");
    a_accept_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");
endmodule

/* sim/tdip_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdip_checker
// Watches both stream channels of the torque to dipole block, computes the
// expected dipole and flags for each accepted input beat, and compares each
// output beat in order. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module tdip_checker
    import tdip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_W-1:0]    i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [SIN_W-1:0]    i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [MOUT_W-1:0]   i_m_tdata,
    input  logic [MUSER_W-1:0]  i_m_tuser,
    output int                  o_errors,
    output int                  o_pending
);
    typedef struct packed {
        logic [DIPOLE_W-1:0] dz;
        logic [DIPOLE_W-1:0] dy;
        logic [DIPOLE_W-1:0] dx;
        logic                clipped;
        logic                too_weak;
    } t_dipole;

    t_dipole            dipole_q[$];
    logic [THR_W-1:0]   thresh;
    int                 beat_no;

    function automatic logic [DIPOLE_W-1:0] div_sat(longint num, longint den,
                                                    inout logic sat);
        longint q;
        q = num / den;  // truncates toward zero
        if (q > 64'sd8388607) begin
            q = 8388607;
            sat = 1'b1;
        end else if (q < -64'sd8388608) begin
            q = -8388608;
            sat = 1'b1;
        end
        return q[DIPOLE_W-1:0];
    endfunction

    function automatic t_dipole calc_dipole(logic [SIN_W-1:0] d,
                                            logic [THR_W-1:0] thr);
        longint bx, by, bz, tx, ty, tz, nsq;
        logic sat;
        t_dipole r;
        bx = longint'($signed(d[17:0]));
        by = longint'($signed(d[35:18]));
        bz = longint'($signed(d[53:36]));
        tx = longint'($signed(d[78:54]));
        ty = longint'($signed(d[103:79]));
        tz = longint'($signed(d[128:104]));
        nsq = bx * bx + by * by + bz * bz;
        sat = 1'b0;
        r = '0;
        if (nsq <= longint'({28'd0, thr})) begin
            r.too_weak = 1'b1;
            return r;
        end
        r.dx = div_sat((by * tz - bz * ty) * 1000, nsq, sat);
        r.dy = div_sat((bz * tx - bx * tz) * 1000, nsq, sat);
        r.dz = div_sat((bx * ty - by * tx) * 1000, nsq, sat);
        r.clipped = sat;
        return r;
    endfunction

    task automatic report(string what, int idx, longint got, longint want);
        $display("mismatch beat %0d %s: got %0d expected %0d", idx, what, got, want);
        o_errors++;
    endtask

    assign o_pending = dipole_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_dipole e;
        if (!i_rst_n) begin
            thresh <= THR_RESET;
            beat_no <= 0;
            dipole_q.delete();
        end else begin
            if (i_cfg_we)
                thresh <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                dipole_q.push_back(calc_dipole(i_s_tdata, thresh));
            if (i_m_tvalid && i_m_tready) begin
                if (dipole_q.size() == 0) begin
                    report("unexpected beat", beat_no, 0, 0);
                end else begin
                    e = dipole_q.pop_front();
                    if (i_m_tdata[23:0] !== e.dx)
                        report("dipole_x", beat_no, $signed(i_m_tdata[23:0]), $signed(e.dx));
                    if (i_m_tdata[47:24] !== e.dy)
                        report("dipole_y", beat_no, $signed(i_m_tdata[47:24]), $signed(e.dy));
                    if (i_m_tdata[71:48] !== e.dz)
                        report("dipole_z", beat_no, $signed(i_m_tdata[71:48]), $signed(e.dz));
                    if (i_m_tuser[0] !== e.too_weak)
                        report("field_too_weak", beat_no, i_m_tuser[0], e.too_weak);
                    if (i_m_tuser[1] !== e.clipped)
                        report("clipped", beat_no, i_m_tuser[1], e.clipped);
                end
                beat_no <= beat_no + 1;
            end
        end
    end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the torque to dipole block: directed corner beats, then random
// field and torque vectors under several thresholds, with random idling on
// both streams and one long output stall. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb_top;
    import tdip_pkg::*;

    localparam int WATCHDOG = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [THR_W-1:0]   i_cfg_wdata;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [SIN_W-1:0]   i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [MOUT_W-1:0]  o_m_tdata;
    logic [MUSER_W-1:0] o_m_tuser;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 src_busy_mode;
    bit                 sink_calm;
    bit                 sink_hold;

    torque_to_magnetic_dipole DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    tdip_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [17:0] rand_field(int mode);
        case (mode)
            0: return 18'($urandom);
            1: return 18'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
            default: return 18'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [24:0] rand_torque(int mode);
        case (mode)
            0: return 25'($urandom);
            1: return 25'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 25'h0ffffff : 25'h1000000;
            default: return 25'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [SIN_W-1:0] pack_beat(logic [17:0] bx, logic [17:0] by,
            logic [17:0] bz, logic [24:0] tx, logic [24:0] ty, logic [24:0] tz);
        return {7'd0, tz, ty, tx, bz, by, bx};
    endfunction

    // tvalid stays high between beats unless an idle cycle is drawn
    task automatic send(logic [SIN_W-1:0] d);
        if (!src_busy_mode && $urandom_range(0, 99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while (!src_busy_mode && $urandom_range(0, 99) < 31)
                @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        int fm, tm;
        repeat (n) begin
            fm = $urandom_range(0, 3);
            tm = $urandom_range(0, 3);
            send(pack_beat(rand_field(fm), rand_field(fm), rand_field(fm),
                           rand_torque(tm), rand_torque(tm), rand_torque(tm)));
        end
    endtask

    task automatic drain_and_write(logic [THR_W-1:0] v);
        i_s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // output side: random backpressure, calm stretch, one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= sink_calm || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_s_tready && i_s_tvalid) || (o_m_tvalid && i_m_tready)
            || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("** torque_to_magnetic_dipole: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        src_busy_mode = 1'b0;
        sink_calm = 1'b0;
        sink_hold = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero field, threshold edge, extremes, saturation
        send(pack_beat('0, '0, '0, 25'h0ffffff, 25'h1000000, 25'h0ffffff));
        send(pack_beat(18'd1, '0, '0, '0, 25'd5, 25'd7));
        send(pack_beat(18'd1, 18'd1, '0, 25'd3, 25'd5, 25'd7));
        send(pack_beat(18'h1ffff, 18'h1ffff, 18'h1ffff, 25'h0ffffff, 25'h1000000, '0));
        send(pack_beat(18'h20000, 18'h20000, 18'h20000, 25'h1000000, 25'h1000000,
                       25'h1000000));
        send(pack_beat(18'h20000, '0, '0, '0, 25'h1000000, 25'h0ffffff));
        send(pack_beat(18'd1, 18'd1, 18'd0, 25'h1000000, 25'h0ffffff, 25'h0ffffff));
        send(pack_beat(18'h3ffff, 18'd1, 18'd0, 25'h0ffffff, 25'h1000000, 25'h1000000));
        send(pack_beat(18'd0, 18'd2, 18'd0, 25'd1, '0, 25'h1ffffff));
        send(pack_beat(18'h1ffff, '0, '0, '0, 25'd1, 25'h1ffffff));
        send(pack_beat(18'h15555, 18'h2aaaa, 18'h0aaaa, 25'h0aaaaaa, 25'h1555555,
                       25'h0555555));

        drain_and_write('0);
        send(pack_beat('0, '0, '0, 25'd9, 25'd9, 25'd9));
        send(pack_beat(18'd1, '0, '0, '0, 25'h0ffffff, 25'h1000000));
        send_random(60);

        drain_and_write({THR_W{1'b1}});
        send(pack_beat(18'h20000, 18'h20000, 18'h20000, 25'd1, 25'd2, 25'd3));
        send_random(20);

        drain_and_write(36'd1000000);
        send(pack_beat(18'd1000, '0, '0, '0, 25'd9, 25'd9));
        send(pack_beat(18'd1001, '0, '0, '0, 25'd9, 25'd9));
        send_random(100);

        // long output stall while inputs keep coming
        drain_and_write(36'd1);
        fork
            begin
                sink_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                src_busy_mode = 1'b1;
                send_random(80);
                src_busy_mode = 1'b0;
            end
        join

        // stretch without idling on either side
        sink_calm = 1'b1;
        src_busy_mode = 1'b1;
        send_random(80);
        sink_calm = 1'b0;
        src_busy_mode = 1'b0;

        drain_and_write(36'($urandom) | 36'h400000000 >> $urandom_range(0, 20));
        send_random(100);

        i_s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("** torque_to_magnetic_dipole: PASSED **");
        else
            $display("** torque_to_magnetic_dipole: FAILED **");
        $finish;
    end
endmodule

/* filelist.f */
src/tdip_pkg.sv
src/tdip_div.sv
src/torque_to_magnetic_dipole.sv
sim/tdip_checker.sv
sim/tb_top.sv
